@@ rtl/led_matrix_chain_framebuffer_core_assert.svh @@
// ----------------------------------------------------------------------------
// led_matrix_chain_framebuffer_core_assert.svh
// Assertion macros shared by the frame buffer RTL.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_CHAIN_FRAMEBUFFER_CORE_ASSERT_SVH
`define LED_MATRIX_CHAIN_FRAMEBUFFER_CORE_ASSERT_SVH

// same-cycle implication
`define LMFB_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lmfb assertion failed");

// next-cycle implication
`define LMFB_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lmfb assertion failed");

`endif

@@ rtl/lmfb_pkg.sv @@
// ----------------------------------------------------------------------------
// lmfb_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lmfb_pkg;

    localparam int ROW_COUNT        = 8;
    localparam int MAX_PHYS_MODULES = 8;
    localparam int MAX_VIRT_MODULES = 16;

    localparam int ROW_W    = $clog2(ROW_COUNT);
    localparam int VIDX_W   = $clog2(MAX_VIRT_MODULES);
    localparam int PIDX_W   = $clog2(MAX_PHYS_MODULES);
    localparam int ST_DEPTH = ROW_COUNT * MAX_VIRT_MODULES;
    localparam int SH_DEPTH = ROW_COUNT * MAX_PHYS_MODULES;
    localparam int PHYS_W   = 4;
    localparam int VIRT_W   = 5;

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROW_COUNT - 1);

    // item command codes
    localparam logic [3:0] CMD_SET_PIXEL = 4'd0;
    localparam logic [3:0] CMD_CLR_PIXEL = 4'd1;
    localparam logic [3:0] CMD_ROW_ON    = 4'd2;
    localparam logic [3:0] CMD_ROW_OFF   = 4'd3;
    localparam logic [3:0] CMD_ALL_ON    = 4'd4;
    localparam logic [3:0] CMD_ALL_OFF   = 4'd5;
    localparam logic [3:0] CMD_SCROLL    = 4'd6;
    localparam logic [3:0] CMD_FLUSH     = 4'd7;
    localparam logic [3:0] CMD_BRIGHT    = 4'd8;

    // configuration register indexes
    localparam logic [1:0] CFG_PHYS_MODULES  = 2'd0;
    localparam logic [1:0] CFG_VIRT_MODULES  = 2'd1;
    localparam logic [1:0] CFG_REVERSE_ORDER = 2'd2;

    localparam logic [3:0] BRIGHT_ADDR = 4'hA;
    localparam logic [7:0] BYTE_ON     = 8'hFF;
    localparam logic [7:0] BYTE_OFF    = 8'h00;

    typedef enum logic [2:0] {
        WR_SET_BIT,
        WR_CLR_BIT,
        WR_FILL_ON,
        WR_FILL_OFF,
        WR_SHIFT
    } st_wsel_t;

    typedef enum logic [1:0] {
        TX_STORE,
        TX_SHOWN,
        TX_BRIGHT
    } tx_src_t;

    typedef struct packed {
        logic              st_rd;
        logic              st_wr;
        st_wsel_t          st_wsel;
        logic [ROW_W-1:0]  row;
        logic [VIDX_W-1:0] idx;
        logic [2:0]        bit_pos;
        logic              sh_rd;
        logic              sh_wr;
        logic              carry_cap;
        logic              carry_wrap;
        logic              emit;
        tx_src_t           tx_src;
        logic              tx_zero;
        logic              frame_end;
        logic              last;
        logic [3:0]        level;
        logic              dirty_set;
        logic              dirty_clr;
    } lmfb_cmd_t;

    typedef struct packed {
        logic                 out_free;
        logic [PHYS_W-1:0]    phys;
        logic [VIRT_W-1:0]    virt;
        logic [ROW_COUNT-1:0] dirty;
    } lmfb_sts_t;

endpackage

@@ rtl/lmfb_ram.sv @@
// ----------------------------------------------------------------------------
// lmfb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/lmfb_datapath.sv @@
// ----------------------------------------------------------------------------
// lmfb_datapath
// Config registers, pixel store, shadow store, dirty bits, output register.
// ----------------------------------------------------------------------------
`include "led_matrix_chain_framebuffer_core_assert.svh"

module lmfb_datapath import lmfb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  lmfb_cmd_t   dp_cmd,
    output lmfb_sts_t   dp_sts,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_reg_addr,
    output logic [7:0]  m_reg_data,
    output logic        m_frame_end,
    output logic        m_last
);

    localparam int ST_AW = $clog2(ST_DEPTH);
    localparam int SH_AW = $clog2(SH_DEPTH);

    logic [PHYS_W-1:0]    phys_reg;
    logic [VIRT_W-1:0]    virt_reg;
    logic                 rev_reg;
    logic [ST_DEPTH-1:0]  st_vld_reg;
    logic [SH_DEPTH-1:0]  sh_vld_reg;
    logic                 st_rv_reg;
    logic                 sh_rv_reg;
    logic                 carry_reg;
    logic [ROW_COUNT-1:0] dirty_reg;
    logic                 m_valid_reg;
    logic [3:0]           m_addr_reg;
    logic [7:0]           m_data_reg;
    logic                 m_fe_reg;
    logic                 m_last_reg;

    logic [ST_AW-1:0]     st_addr;
    logic [SH_AW-1:0]     sh_addr;
    logic [7:0]           st_rdata;
    logic [7:0]           sh_rdata;
    logic [7:0]           st_data;
    logic [7:0]           sh_data;
    logic [7:0]           st_wdata;
    logic [7:0]           bit_mask;
    logic [7:0]           tx_byte;
    logic [7:0]           tx_data;
    logic                 cfg_we;
    logic [PHYS_W-1:0]    phys_sat;
    logic [VIRT_W-1:0]    virt_sat;
    logic                 out_free;

    function automatic logic [7:0] flip_byte(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7 - i];
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb begin
        phys_sat = cfg_data[PHYS_W-1:0];
        if (phys_sat == '0) begin
            phys_sat = PHYS_W'(1);
        end else if (phys_sat > PHYS_W'(MAX_PHYS_MODULES)) begin
            phys_sat = PHYS_W'(MAX_PHYS_MODULES);
        end
        virt_sat = cfg_data[VIRT_W-1:0];
        if (virt_sat == '0) begin
            virt_sat = VIRT_W'(1);
        end else if (virt_sat > VIRT_W'(MAX_VIRT_MODULES)) begin
            virt_sat = VIRT_W'(MAX_VIRT_MODULES);
        end
    end

    assign st_addr  = {dp_cmd.row, dp_cmd.idx};
    assign sh_addr  = {dp_cmd.row, dp_cmd.idx[PIDX_W-1:0]};
    assign st_data  = st_rv_reg ? st_rdata : 8'h00;
    assign sh_data  = sh_rv_reg ? sh_rdata : 8'h00;
    assign bit_mask = 8'h01 << dp_cmd.bit_pos;

    always_comb begin
        case (dp_cmd.st_wsel)
            WR_SET_BIT:  st_wdata = st_data | bit_mask;
            WR_CLR_BIT:  st_wdata = st_data & ~bit_mask;
            WR_FILL_ON:  st_wdata = BYTE_ON;
            WR_FILL_OFF: st_wdata = BYTE_OFF;
            WR_SHIFT:    st_wdata = {carry_reg, st_data[7:1]};
            default:     st_wdata = BYTE_OFF;
        endcase
    end

    lmfb_ram #(
        .WIDTH (8),
        .DEPTH (ST_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (dp_cmd.st_wr),
        .waddr (st_addr),
        .wdata (st_wdata),
        .re    (dp_cmd.st_rd),
        .raddr (st_addr),
        .rdata (st_rdata)
    );

    lmfb_ram #(
        .WIDTH (8),
        .DEPTH (SH_DEPTH)
    ) u_shown (
        .aclk  (aclk),
        .we    (dp_cmd.sh_wr),
        .waddr (sh_addr),
        .wdata (st_data),
        .re    (dp_cmd.sh_rd),
        .raddr (sh_addr),
        .rdata (sh_rdata)
    );

    always_comb begin
        case (dp_cmd.tx_src)
            TX_STORE:  tx_byte = dp_cmd.tx_zero ? 8'h00 : st_data;
            TX_SHOWN:  tx_byte = sh_data;
            TX_BRIGHT: tx_byte = {4'h0, dp_cmd.level};
            default:   tx_byte = 8'h00;
        endcase
        if (rev_reg && dp_cmd.tx_src != TX_BRIGHT) begin
            tx_data = flip_byte(tx_byte);
        end else begin
            tx_data = tx_byte;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phys_reg    <= PHYS_W'(4);
            virt_reg    <= VIRT_W'(8);
            rev_reg     <= 1'b0;
            st_vld_reg  <= '0;
            sh_vld_reg  <= '0;
            st_rv_reg   <= 1'b0;
            sh_rv_reg   <= 1'b0;
            carry_reg   <= 1'b0;
            dirty_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == CFG_PHYS_MODULES) begin
                phys_reg <= phys_sat;
            end
            if (cfg_we && cfg_index == CFG_REVERSE_ORDER) begin
                rev_reg <= cfg_data[0];
            end
            if (cfg_we && cfg_index == CFG_VIRT_MODULES) begin
                virt_reg   <= virt_sat;
                st_vld_reg <= '0;
            end else if (dp_cmd.st_wr) begin
                st_vld_reg[st_addr] <= 1'b1;
            end
            if (dp_cmd.sh_wr) begin
                sh_vld_reg[sh_addr] <= 1'b1;
            end
            if (dp_cmd.st_rd) begin
                st_rv_reg <= st_vld_reg[st_addr];
            end
            if (dp_cmd.sh_rd) begin
                sh_rv_reg <= sh_vld_reg[sh_addr];
            end
            if (dp_cmd.carry_cap) begin
                carry_reg <= dp_cmd.carry_wrap && st_data[0];
            end else if (dp_cmd.st_wr && dp_cmd.st_wsel == WR_SHIFT) begin
                carry_reg <= st_data[0];
            end
            if (dp_cmd.dirty_set) begin
                dirty_reg[dp_cmd.row] <= 1'b1;
            end else if (dp_cmd.dirty_clr) begin
                dirty_reg[dp_cmd.row] <= 1'b0;
            end
            if (dp_cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.emit) begin
            m_addr_reg <= (dp_cmd.tx_src == TX_BRIGHT) ? BRIGHT_ADDR
                                                       : 4'({1'b0, dp_cmd.row} + 4'd1);
            m_data_reg <= tx_data;
            m_fe_reg   <= dp_cmd.frame_end;
            m_last_reg <= dp_cmd.last;
        end
    end

    assign dp_sts.out_free = out_free;
    assign dp_sts.phys     = phys_reg;
    assign dp_sts.virt     = virt_reg;
    assign dp_sts.dirty    = dirty_reg;

    assign m_valid     = m_valid_reg;
    assign m_reg_addr  = m_addr_reg;
    assign m_reg_data  = m_data_reg;
    assign m_frame_end = m_fe_reg;
    assign m_last      = m_last_reg;

    `LMFB_ASSERT_NEXT(a_emit_shows_valid, aclk, aresetn, dp_cmd.emit, m_valid)
    `LMFB_ASSERT_IMPL(a_last_ends_frame, aclk, aresetn, m_valid && m_last, m_frame_end)
    `LMFB_ASSERT_NEXT(a_stall_holds_valid, aclk, aresetn, m_valid && !m_ready, m_valid)

endmodule

@@ rtl/lmfb_ctrl.sv @@
// ----------------------------------------------------------------------------
// lmfb_ctrl
// Command sequencer: pixel and fill writes, scroll, flush, brightness and frame sending.
// ----------------------------------------------------------------------------
`include "led_matrix_chain_framebuffer_core_assert.svh"

module lmfb_ctrl import lmfb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_cmd,
    input  logic [2:0]  s_row,
    input  logic [6:0]  s_col,
    input  logic        s_flush_after,
    input  logic        s_wrap,
    input  logic [3:0]  s_level,
    input  lmfb_sts_t   dp_sts,
    output lmfb_cmd_t   dp_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PIX_RD,
        S_PIX_WR,
        S_FILL,
        S_FL_RD,
        S_FL_WR,
        S_SC_CAP_RD,
        S_SC_CAP,
        S_SC_RD,
        S_SC_WR,
        S_TX_RD,
        S_TX_EMIT,
        S_ROW_END,
        S_BRIGHT
    } state_t;

    state_t            state_reg, state_next;
    logic [3:0]        cmd_reg, cmd_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [VIDX_W-1:0] idx_reg, idx_next;
    logic [2:0]        bit_reg, bit_next;
    logic              fl_reg, fl_next;
    logic              wrap_reg, wrap_next;
    logic [3:0]        level_reg, level_next;

    logic [VIRT_W-1:0] virt_m1;
    logic [VIDX_W-1:0] virt_last;
    logic [PHYS_W-1:0] phys_m1;
    logic [PIDX_W-1:0] phys_last;
    logic [VIRT_W-1:0] cnt;
    logic [VIRT_W-1:0] cnt_m1;
    logic [PIDX_W-1:0] cnt_last;
    logic              is_scroll;
    logic              is_all;
    logic              is_on;
    logic              more_dirty;
    logic              accept;

    assign virt_m1    = dp_sts.virt - VIRT_W'(1);
    assign virt_last  = virt_m1[VIDX_W-1:0];
    assign phys_m1    = dp_sts.phys - PHYS_W'(1);
    assign phys_last  = phys_m1[PIDX_W-1:0];
    assign cnt        = (VIRT_W'(dp_sts.phys) < dp_sts.virt) ? VIRT_W'(dp_sts.phys)
                                                             : dp_sts.virt;
    assign cnt_m1     = cnt - VIRT_W'(1);
    assign cnt_last   = cnt_m1[PIDX_W-1:0];
    assign is_scroll  = (cmd_reg == CMD_SCROLL);
    assign is_all     = (cmd_reg == CMD_ALL_ON) || (cmd_reg == CMD_ALL_OFF);
    assign is_on      = (cmd_reg == CMD_ROW_ON) || (cmd_reg == CMD_ALL_ON);
    assign more_dirty = |(dp_sts.dirty & ({{(ROW_COUNT-1){1'b1}}, 1'b0} << row_reg));
    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        row_next   = row_reg;
        idx_next   = idx_reg;
        bit_next   = bit_reg;
        fl_next    = fl_reg;
        wrap_next  = wrap_reg;
        level_next = level_reg;

        dp_cmd            = '0;
        dp_cmd.st_wsel    = WR_SET_BIT;
        dp_cmd.tx_src     = TX_SHOWN;
        dp_cmd.row        = row_reg;
        dp_cmd.idx        = idx_reg;
        dp_cmd.bit_pos    = bit_reg;
        dp_cmd.carry_wrap = wrap_reg;
        dp_cmd.level      = level_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next   = s_cmd;
                    fl_next    = s_flush_after;
                    wrap_next  = s_wrap;
                    level_next = s_level;
                    row_next   = '0;
                    idx_next   = '0;
                    case (s_cmd) inside
                        CMD_SET_PIXEL, CMD_CLR_PIXEL: begin
                            row_next = s_row;
                            idx_next = s_col[6:3];
                            bit_next = s_col[2:0];
                            if (VIRT_W'(s_col[6:3]) < dp_sts.virt) begin
                                state_next = S_PIX_RD;
                            end
                        end
                        CMD_ROW_ON, CMD_ROW_OFF: begin
                            row_next   = s_row;
                            state_next = S_FILL;
                        end
                        CMD_ALL_ON, CMD_ALL_OFF: state_next = S_FILL;
                        CMD_SCROLL:              state_next = S_SC_CAP_RD;
                        CMD_FLUSH:               state_next = S_FL_RD;
                        CMD_BRIGHT: begin
                            idx_next   = VIDX_W'(phys_last);
                            state_next = S_BRIGHT;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_PIX_RD: begin
                dp_cmd.st_rd = 1'b1;
                state_next   = S_PIX_WR;
            end
            S_PIX_WR: begin
                dp_cmd.st_wr     = 1'b1;
                dp_cmd.st_wsel   = (cmd_reg == CMD_SET_PIXEL) ? WR_SET_BIT : WR_CLR_BIT;
                dp_cmd.dirty_set = 1'b1;
                row_next         = '0;
                idx_next         = '0;
                state_next       = fl_reg ? S_FL_RD : S_IDLE;
            end
            S_FILL: begin
                dp_cmd.st_wr     = 1'b1;
                dp_cmd.st_wsel   = is_on ? WR_FILL_ON : WR_FILL_OFF;
                dp_cmd.dirty_set = 1'b1;
                if (idx_reg == virt_last) begin
                    idx_next = '0;
                    if (is_all && row_reg != ROW_LAST) begin
                        row_next = row_reg + ROW_W'(1);
                    end else begin
                        row_next   = '0;
                        state_next = fl_reg ? S_FL_RD : S_IDLE;
                    end
                end else begin
                    idx_next = idx_reg + VIDX_W'(1);
                end
            end
            S_FL_RD: begin
                dp_cmd.st_rd = 1'b1;
                state_next   = S_FL_WR;
            end
            S_FL_WR: begin
                dp_cmd.sh_wr = 1'b1;
                if (idx_reg == VIDX_W'(cnt_last)) begin
                    if (dp_sts.dirty[row_reg]) begin
                        idx_next   = VIDX_W'(phys_last);
                        state_next = S_TX_RD;
                    end else begin
                        state_next = S_ROW_END;
                    end
                end else begin
                    idx_next   = idx_reg + VIDX_W'(1);
                    state_next = S_FL_RD;
                end
            end
            S_SC_CAP_RD: begin
                dp_cmd.st_rd = 1'b1;
                dp_cmd.idx   = '0;
                state_next   = S_SC_CAP;
            end
            S_SC_CAP: begin
                dp_cmd.carry_cap = 1'b1;
                idx_next         = virt_last;
                state_next       = S_SC_RD;
            end
            S_SC_RD: begin
                dp_cmd.st_rd = 1'b1;
                state_next   = S_SC_WR;
            end
            S_SC_WR: begin
                dp_cmd.st_wr   = 1'b1;
                dp_cmd.st_wsel = WR_SHIFT;
                if (idx_reg == '0) begin
                    idx_next   = VIDX_W'(phys_last);
                    state_next = S_TX_RD;
                end else begin
                    idx_next   = idx_reg - VIDX_W'(1);
                    state_next = S_SC_RD;
                end
            end
            S_TX_RD: begin
                dp_cmd.st_rd = is_scroll;
                dp_cmd.sh_rd = !is_scroll;
                state_next   = S_TX_EMIT;
            end
            S_TX_EMIT: begin
                dp_cmd.emit      = dp_sts.out_free;
                dp_cmd.tx_src    = is_scroll ? TX_STORE : TX_SHOWN;
                dp_cmd.tx_zero   = VIRT_W'(idx_reg) >= dp_sts.virt;
                dp_cmd.frame_end = (idx_reg == '0);
                dp_cmd.last      = (idx_reg == '0) &&
                                   (is_scroll ? (row_reg == ROW_LAST) : !more_dirty);
                if (dp_sts.out_free) begin
                    if (idx_reg == '0) begin
                        state_next = S_ROW_END;
                    end else begin
                        idx_next   = idx_reg - VIDX_W'(1);
                        state_next = S_TX_RD;
                    end
                end
            end
            S_ROW_END: begin
                dp_cmd.dirty_clr = !is_scroll;
                idx_next         = '0;
                if (row_reg == ROW_LAST) begin
                    state_next = S_IDLE;
                end else begin
                    row_next   = row_reg + ROW_W'(1);
                    state_next = is_scroll ? S_SC_CAP_RD : S_FL_RD;
                end
            end
            S_BRIGHT: begin
                dp_cmd.emit      = dp_sts.out_free;
                dp_cmd.tx_src    = TX_BRIGHT;
                dp_cmd.frame_end = (idx_reg == '0);
                dp_cmd.last      = (idx_reg == '0);
                if (dp_sts.out_free) begin
                    if (idx_reg == '0) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next = idx_reg - VIDX_W'(1);
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cmd_reg   <= '0;
            row_reg   <= '0;
            idx_reg   <= '0;
            bit_reg   <= '0;
            fl_reg    <= 1'b0;
            wrap_reg  <= 1'b0;
            level_reg <= '0;
        end else begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            row_reg   <= row_next;
            idx_reg   <= idx_next;
            bit_reg   <= bit_next;
            fl_reg    <= fl_next;
            wrap_reg  <= wrap_next;
            level_reg <= level_next;
        end
    end

    `LMFB_ASSERT_IMPL(a_emit_needs_room, aclk, aresetn, dp_cmd.emit, dp_sts.out_free)
    `LMFB_ASSERT_IMPL(a_store_rd_wr_split, aclk, aresetn, dp_cmd.st_wr, !dp_cmd.st_rd)
    `LMFB_ASSERT_IMPL(a_idle_is_quiet, aclk, aresetn, s_ready, !dp_cmd.emit && !dp_cmd.st_wr)

endmodule

@@ rtl/led_matrix_chain_framebuffer_core.sv @@
// ----------------------------------------------------------------------------
// led_matrix_chain_framebuffer_core
// Frame buffer and frame sender for a daisy-chained row of 8x8 LED drivers.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------
//   s_       | s_valid / s_ready     | cmd, row, col, flush_after, wrap, level
//   m_       | m_valid / m_ready     | reg_addr, reg_data, frame_end, last
//   cfg_     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item at a time. A pixel write reads, then rewrites a store byte; fill writes
// one module per cycle; flush copies rows to the shown store and sends dirty rows;
// scroll shifts each row by one pixel and sends it; brightness sends one write per
// physical module. Store accesses are paced by the single read port and registered
// read of the store RAMs. Reset loads phys 4, virt 8, no reversal; per-entry valid
// bits make both stores read as zero at once, so no clearing pass is needed.
// A stalled m_ ready holds the sequencer in its send step.
// ----------------------------------------------------------------------------
module led_matrix_chain_framebuffer_core import lmfb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_cmd,
    input  logic [2:0]  s_row,
    input  logic [6:0]  s_col,
    input  logic        s_flush_after,
    input  logic        s_wrap,
    input  logic [3:0]  s_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_reg_addr,
    output logic [7:0]  m_reg_data,
    output logic        m_frame_end,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    lmfb_cmd_t dp_cmd;
    lmfb_sts_t dp_sts;

    lmfb_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_row         (s_row),
        .s_col         (s_col),
        .s_flush_after (s_flush_after),
        .s_wrap        (s_wrap),
        .s_level       (s_level),
        .dp_sts        (dp_sts),
        .dp_cmd        (dp_cmd)
    );

    lmfb_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .dp_cmd      (dp_cmd),
        .dp_sts      (dp_sts),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_reg_addr  (m_reg_addr),
        .m_reg_data  (m_reg_data),
        .m_frame_end (m_frame_end),
        .m_last      (m_last)
    );

endmodule
